/* design/pms_pkg.sv */
package pms_pkg;

    localparam int MAX_MOTIF_LEN = 32;
    localparam int LEN_W         = 6;
    localparam int IDX_W         = 5;
    localparam int WEIGHT_BITS   = 16;
    localparam int POSITION_BITS = 32;
    localparam int SCORE_W       = 21;
    localparam int ACC_W         = WEIGHT_BITS + IDX_W + 1;
    localparam int NUM_ORI       = 4;
    localparam int CFG_DATA_W    = 21;
    localparam int CFG_IDX_W     = 2;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_BASE = 2'd1;
    localparam logic [1:0] ACT_NEW  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 2'd2;

    localparam logic [1:0] ORI_SENSE = 2'd0;
    localparam logic [1:0] ORI_REV   = 2'd1;
    localparam logic [1:0] ORI_COMP  = 2'd2;
    localparam logic [1:0] ORI_RC    = 2'd3;

    localparam logic signed [ACC_W-1:0] SCORE_MAX = ACC_W'(1048575);
    localparam logic signed [ACC_W-1:0] SCORE_MIN = -ACC_W'(1048576);

    typedef struct packed {
        logic take;
        logic start;
        logic issue;
        logic load_pend;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic window_ok;
        logic scan_last;
        logic s1_valid;
        logic pend_any;
        logic out_free;
        logic emit_last;
    } t_status;

    function automatic logic [1:0] ori_of_slot(input logic [1:0] slot);
        logic [1:0] ori;
        unique case (slot)
            2'd0:    ori = ORI_SENSE;
            2'd1:    ori = ORI_COMP;
            2'd2:    ori = ORI_REV;
            default: ori = ORI_RC;
        endcase
        return ori;
    endfunction

    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] c;
        c = acc;
        if (acc > SCORE_MAX) c = SCORE_MAX;
        if (acc < SCORE_MIN) c = SCORE_MIN;
        return c[SCORE_W-1:0];
    endfunction

endpackage

/* design/pms_ctrl.sv */
module pms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_action,
    input  pms_pkg::t_status  i_status,
    output logic              o_ready,
    output pms_pkg::t_cmd     o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
                if (i_valid && i_action == pms_pkg::ACT_BASE) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.start = 1'b1;
                n_state = i_status.window_ok ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!i_status.s1_valid) begin
                    o_cmd.load_pend = 1'b1;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.pend_any) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* design/pms_datapath.sv */
module pms_datapath (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pms_pkg::t_cmd                            i_cmd,
    output pms_pkg::t_status                         o_status,
    input  logic                                     i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    input  logic [1:0]                               i_action,
    input  logic [4:0]                               i_weight_row,
    input  logic [1:0]                               i_weight_column,
    input  logic signed [15:0]                       i_weight_value,
    input  logic [7:0]                               i_base,
    input  logic                                     i_out_ready,
    output logic                                     o_out_valid,
    output logic [pms_pkg::POSITION_BITS-1:0]        o_match_position,
    output logic [1:0]                               o_orientation,
    output logic signed [pms_pkg::SCORE_W-1:0]       o_match_score,
    output logic                                     o_last_of_run
);

    localparam int LW = pms_pkg::LEN_W;
    localparam int IW = pms_pkg::IDX_W;
    localparam int AW = pms_pkg::ACC_W;
    localparam int WB = pms_pkg::WEIGHT_BITS;
    localparam int PB = pms_pkg::POSITION_BITS;
    localparam int SW = pms_pkg::SCORE_W;

    logic [LW-1:0]        r_len_cfg;
    logic signed [SW-1:0] r_thr;
    logic [3:0]           r_mask;
    logic [PB-1:0]        r_seen;
    logic [LW-1:0]        r_run;
    logic [1:0]           r_code [pms_pkg::MAX_MOTIF_LEN];
    logic [IW-1:0]        r_i;
    logic [WB-1:0]        r_wmem [4][pms_pkg::MAX_MOTIF_LEN];
    logic [WB-1:0]        r_rd_a [4];
    logic [WB-1:0]        r_rd_b [4];
    logic                 r_s1_valid;
    logic [1:0]           r_s1_code;
    logic signed [AW-1:0] r_sum [4];
    logic [3:0]           r_pend;
    logic                 r_out_valid;
    logic [PB-1:0]        r_pos;
    logic [1:0]           r_ori;
    logic signed [SW-1:0] r_score;
    logic                 r_last;

    logic [LW-1:0]        len_eff;
    logic [LW-1:0]        len_m1;
    logic [IW-1:0]        j;
    logic                 base_ok;
    logic [1:0]           base_code;
    logic signed [SW-1:0] score [4];
    logic [3:0]           pass;
    logic [3:0]           pick;
    logic [1:0]           pick_slot;
    logic [1:0]           pick_ori;
    logic                 out_free;

    always_comb begin
        len_eff = r_len_cfg;
        if (r_len_cfg == '0) len_eff = LW'(1);
        if (r_len_cfg > LW'(pms_pkg::MAX_MOTIF_LEN)) len_eff = LW'(pms_pkg::MAX_MOTIF_LEN);
        len_m1 = len_eff - LW'(1);
        j = len_m1[IW-1:0] - r_i;
    end

    always_comb begin
        base_ok = 1'b1;
        base_code = 2'd0;
        case (i_base)
            8'h41:   base_code = 2'd0;
            8'h43:   base_code = 2'd1;
            8'h47:   base_code = 2'd2;
            8'h54:   base_code = 2'd3;
            default: base_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= LW'(8);
            r_thr     <= '0;
            r_mask    <= 4'hF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pms_pkg::CFG_LEN:  r_len_cfg <= i_cfg_data[LW-1:0];
                pms_pkg::CFG_THR:  r_thr     <= i_cfg_data[SW-1:0];
                pms_pkg::CFG_MASK: r_mask    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_run  <= '0;
        end else if (i_cmd.take) begin
            if (i_action == pms_pkg::ACT_NEW) begin
                r_seen <= '0;
            end else if (i_action == pms_pkg::ACT_BASE) begin
                if (r_seen != '1) r_seen <= r_seen + PB'(1);
                if (!base_ok) begin
                    r_run <= '0;
                end else if (r_run < LW'(pms_pkg::MAX_MOTIF_LEN)) begin
                    r_run <= r_run + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_action == pms_pkg::ACT_BASE) begin
            for (int k = pms_pkg::MAX_MOTIF_LEN - 1; k > 0; k--) begin
                r_code[k] <= r_code[k-1];
            end
            r_code[0] <= base_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_action == pms_pkg::ACT_LOAD
                && {1'b0, i_weight_row} < LW'(pms_pkg::MAX_MOTIF_LEN)) begin
            r_wmem[i_weight_column][i_weight_row] <= i_weight_value[WB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            for (int c = 0; c < 4; c++) begin
                r_rd_a[c] <= r_wmem[c][r_i];
                r_rd_b[c] <= r_wmem[c][j];
            end
            r_s1_code <= r_code[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_i        <= '0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            if (i_cmd.start) begin
                r_i <= '0;
            end else if (i_cmd.issue) begin
                r_i <= r_i + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int o = 0; o < 4; o++) r_sum[o] <= '0;
        end else if (r_s1_valid) begin
            r_sum[pms_pkg::ORI_SENSE] <= r_sum[pms_pkg::ORI_SENSE]
                + AW'($signed(r_rd_a[r_s1_code]));
            r_sum[pms_pkg::ORI_COMP]  <= r_sum[pms_pkg::ORI_COMP]
                + AW'($signed(r_rd_a[~r_s1_code]));
            r_sum[pms_pkg::ORI_REV]   <= r_sum[pms_pkg::ORI_REV]
                + AW'($signed(r_rd_b[r_s1_code]));
            r_sum[pms_pkg::ORI_RC]    <= r_sum[pms_pkg::ORI_RC]
                + AW'($signed(r_rd_b[~r_s1_code]));
        end
    end

    always_comb begin
        for (int o = 0; o < 4; o++) begin
            score[o] = pms_pkg::sat_score(r_sum[o]);
            pass[o]  = r_mask[o] && (score[o] >= r_thr);
        end
        pick = r_pend & (~r_pend + 4'd1);
        pick_slot = 2'd0;
        for (int s = 3; s >= 0; s--) begin
            if (r_pend[s]) pick_slot = 2'(s);
        end
        pick_ori = pms_pkg::ori_of_slot(pick_slot);
        out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (i_cmd.load_pend) begin
            for (int s = 0; s < 4; s++) begin
                r_pend[s] <= pass[pms_pkg::ori_of_slot(2'(s))];
            end
        end else if (i_cmd.emit) begin
            r_pend <= r_pend & ~pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pos   <= r_seen - PB'(len_eff) + PB'(1);
            r_ori   <= pick_ori;
            r_score <= score[pick_ori];
            r_last  <= (r_pend & ~pick) == 4'd0;
        end
    end

    assign o_status.window_ok = (r_seen >= PB'(len_eff)) && (r_run >= len_eff);
    assign o_status.scan_last = r_i == len_m1[IW-1:0];
    assign o_status.s1_valid  = r_s1_valid;
    assign o_status.pend_any  = r_pend != 4'd0;
    assign o_status.out_free  = out_free;
    assign o_status.emit_last = (r_pend & ~pick) == 4'd0;

    assign o_out_valid      = r_out_valid;
    assign o_match_position = r_pos;
    assign o_orientation    = r_ori;
    assign o_match_score    = r_score;
    assign o_last_of_run    = r_last;

endmodule

/* design/pwm_motif_scanner.sv */
// A base transaction with a full window evaluates, reads the weight matrix row-serially, flushes
// and then emits one result per cycle while the output is free; otherwise it returns to idle.
// No new item is taken until a base's scan and results are done; loads and restarts are
// taken in idle without a scan. The four orientation sums share one row scan.
// The next item is taken while a result waits. Reset (synchronous, active low) clears
// control, counters and config to 8 / 0 / 15; the weight matrix is not cleared.
module pwm_motif_scanner (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [1:0]                            i_action,
    input  logic [4:0]                            i_weight_row,
    input  logic [1:0]                            i_weight_column,
    input  logic signed [15:0]                    i_weight_value,
    input  logic [7:0]                            i_base,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [pms_pkg::POSITION_BITS-1:0]     o_match_position,
    output logic [1:0]                            o_orientation,
    output logic signed [pms_pkg::SCORE_W-1:0]    o_match_score,
    output logic                                  o_last_of_run,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    pms_pkg::t_cmd    cmd;
    pms_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    pms_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_action         (i_action),
        .i_weight_row     (i_weight_row),
        .i_weight_column  (i_weight_column),
        .i_weight_value   (i_weight_value),
        .i_base           (i_base),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_match_position (o_match_position),
        .o_orientation    (o_orientation),
        .o_match_score    (o_match_score),
        .o_last_of_run    (o_last_of_run)
    );

    a_base_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_action == pms_pkg::ACT_BASE) |=> !o_ready)
        else $error("base transaction did not start a scan");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_position != '0))
        else $error("match position is zero");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_valid || i_ready))
        else $error("result overwritten before transaction");

endmodule
